[sv/eprs_pkg.sv]
// Shared constants, codes and types for the encoder period speed regulator.
package eprs_pkg;

    // Fixed field widths
    localparam int CAP_W      = 16;
    localparam int DUTY_W     = 10;
    localparam int TGT_CFG_W  = 23;
    localparam int TGT_W      = TGT_CFG_W + 1;
    localparam int PULSE_W    = 24;
    localparam int OP_W       = 2;

    // Stream port widths
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_TUSER_W  = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = TGT_CFG_W;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEFT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DUTY = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD   = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [TGT_CFG_W-1:0] TARGET_RIGHT_RST = TGT_CFG_W'(65000);
    localparam logic [TGT_CFG_W-1:0] TARGET_LEFT_RST  = TGT_CFG_W'(65500);
    localparam logic [DUTY_W-1:0]    INITIAL_DUTY_RST = DUTY_W'(240);
    localparam logic [DUTY_W-1:0]    PWM_PERIOD_RST   = DUTY_W'(960);

    // Parameter defaults
    localparam int AVG_SAMPLES_DEF = 6;
    localparam int TIMER_WRAP_DEF  = 65536;
    localparam int PERIOD_BITS_DEF = 24;

    // Event codes
    typedef enum logic [OP_W-1:0] {
        OP_OVERFLOW  = 2'd0,
        OP_CAP_RIGHT = 2'd1,
        OP_CAP_LEFT  = 2'd2,
        OP_RESTART   = 2'd3
    } eprs_op_t;

    // Per-wheel event strobes, already qualified by the pipeline advance
    typedef struct packed {
        logic ovf;
        logic cap;
        logic restart;
        logic hs;
    } eprs_ev_t;

endpackage

[sv/eprs_wrap.sv]
// Reduces a raw capture word modulo the timer wrap by restoring subtraction.
module eprs_wrap #(
    parameter int TIMER_WRAP = eprs_pkg::TIMER_WRAP_DEF
) (
    input  logic [eprs_pkg::CAP_W-1:0]     cap_raw,
    output logic [$clog2(TIMER_WRAP)-1:0]  cap_ticks
);
    import eprs_pkg::*;

    localparam int C_W     = $clog2(TIMER_WRAP);
    localparam int EXT_W   = CAP_W + 2;
    localparam int Q_STEPS = $clog2((2 ** CAP_W) / TIMER_WRAP + 1);

    logic [EXT_W-1:0] rem;

    // One quotient bit per step, most significant first
    always_comb begin
        rem = EXT_W'(cap_raw);
        for (int k = Q_STEPS - 1; k >= 0; k--) begin
            if (rem >= (EXT_W'(TIMER_WRAP) << k)) begin
                rem = rem - (EXT_W'(TIMER_WRAP) << k);
            end
        end
    end

    assign cap_ticks = rem[C_W-1:0];

endmodule

[sv/eprs_wheel.sv]
// One wheel: period capture, pulse count, AVG_SAMPLES-sample average and duty nudge.
module eprs_wheel #(
    parameter int AVG_SAMPLES = eprs_pkg::AVG_SAMPLES_DEF,
    parameter int TIMER_WRAP  = eprs_pkg::TIMER_WRAP_DEF,
    parameter int PERIOD_BITS = eprs_pkg::PERIOD_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  eprs_pkg::eprs_ev_t               ev,
    input  logic [$clog2(TIMER_WRAP)-1:0]    cap_ticks,
    input  logic [eprs_pkg::TGT_CFG_W-1:0]   target,
    input  logic [eprs_pkg::DUTY_W-1:0]      pwm_period,
    input  logic                             duty_load,
    input  logic [eprs_pkg::DUTY_W-1:0]      duty_init,
    output logic [PERIOD_BITS-1:0]           period,
    output logic                             adjusted,
    output logic [eprs_pkg::DUTY_W-1:0]      duty_next,
    output logic [eprs_pkg::PULSE_W-1:0]     pulses_next
);
    import eprs_pkg::*;

    localparam int C_W    = $clog2(TIMER_WRAP);
    localparam int OFS_W  = PERIOD_BITS + 2;
    localparam int SUM_W  = PERIOD_BITS + $clog2(AVG_SAMPLES);
    localparam int CNT_W  = $clog2(AVG_SAMPLES + 1);
    localparam int PROD_W = TGT_W + $clog2(AVG_SAMPLES + 1) + 1;
    localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

    localparam logic signed [OFS_W-1:0] PMAX_S = {2'b00, {PERIOD_BITS{1'b1}}};
    localparam logic signed [OFS_W-1:0] WRAP_S = OFS_W'(TIMER_WRAP);

    logic signed [OFS_W-1:0] ofs_reg, ofs_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DUTY_W-1:0]       duty_reg;
    logic [PULSE_W-1:0]      pulses_reg;

    logic signed [OFS_W-1:0] c_ext, p_raw, ofs_bump;
    logic [SUM_W-1:0]        sum_new;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    avg_done;
    logic [TGT_W-1:0]        tgt;
    logic [CMP_W-1:0]        prod, sum_ext;
    logic                    too_slow, too_fast;
    logic [DUTY_W:0]         step, duty_up;
    logic [DUTY_W-1:0]       duty_dn, duty_adj;

    // Period from overflow offset plus capture, clamped to 0..2^PERIOD_BITS-1
    assign c_ext = signed'(OFS_W'(cap_ticks));
    assign p_raw = ofs_reg + c_ext;

    always_comb begin
        if (p_raw < 0) begin
            period = '0;
        end else if (p_raw > PMAX_S) begin
            period = PMAX_S[PERIOD_BITS-1:0];
        end else begin
            period = p_raw[PERIOD_BITS-1:0];
        end
    end

    // Overflow bumps the offset by one wrap, saturating
    assign ofs_bump = (ofs_reg + WRAP_S > PMAX_S) ? PMAX_S : ofs_reg + WRAP_S;

    // Running sum and sample count
    assign sum_new  = sum_reg + SUM_W'(period);
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign avg_done = (cnt_inc >= CNT_W'(AVG_SAMPLES));

    // floor(sum/N) > T  <=>  sum >= N*T + N ;  floor(sum/N) < T  <=>  sum < N*T
    assign tgt      = ev.hs ? {target, 1'b0} : {1'b0, target};
    assign prod     = CMP_W'(tgt) * CMP_W'(AVG_SAMPLES);
    assign sum_ext  = CMP_W'(sum_new);
    assign too_slow = (sum_ext >= prod + CMP_W'(AVG_SAMPLES));
    assign too_fast = (sum_ext < prod);

    // Bang-bang duty step, clamped to 0..pwm_period
    assign step    = ev.hs ? (DUTY_W+1)'(2) : (DUTY_W+1)'(1);
    assign duty_up = {1'b0, duty_reg} + step;

    always_comb begin
        if ({1'b0, duty_reg} >= step) begin
            duty_dn = duty_reg - step[DUTY_W-1:0];
        end else begin
            duty_dn = '0;
        end
        if (too_slow) begin
            duty_adj = (duty_up > {1'b0, pwm_period}) ? pwm_period : duty_up[DUTY_W-1:0];
        end else if (too_fast) begin
            duty_adj = (duty_dn > pwm_period) ? pwm_period : duty_dn;
        end else begin
            duty_adj = duty_reg;
        end
    end

    // Next state for this wheel
    always_comb begin
        ofs_next    = ofs_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        duty_next   = duty_reg;
        pulses_next = pulses_reg;
        adjusted    = 1'b0;
        if (ev.ovf) begin
            ofs_next = ofs_bump;
        end
        if (ev.cap) begin
            ofs_next = -c_ext;
            if (!(&pulses_reg)) begin
                pulses_next = pulses_reg + PULSE_W'(1);
            end
            if (avg_done) begin
                duty_next = duty_adj;
                cnt_next  = '0;
                sum_next  = '0;
                adjusted  = 1'b1;
            end else begin
                cnt_next = cnt_inc;
                sum_next = sum_new;
            end
        end
        if (ev.restart) begin
            cnt_next    = '0;
            sum_next    = '0;
            pulses_next = '0;
        end
        if (duty_load) begin
            duty_next = duty_init;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_reg    <= '0;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            duty_reg   <= INITIAL_DUTY_RST;
            pulses_reg <= '0;
        end else begin
            ofs_reg    <= ofs_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            duty_reg   <= duty_next;
            pulses_reg <= pulses_next;
        end
    end

endmodule

[sv/encoder_period_speed_regulator_core.sv]
// An accepted input word goes through the input register, then the result
// register. Throughput: one word per cycle while m_tready does not stall the result side; the wheel
// state update and duty nudge sit between the two registers.
// Reset (aresetn, synchronous, active low) empties both stages, loads the
// register defaults, clears offsets, sums, counts and pulse totals, and sets
// both duties to the initial duty default.
module encoder_period_speed_regulator_core #(
    parameter int AVG_SAMPLES = eprs_pkg::AVG_SAMPLES_DEF,
    parameter int TIMER_WRAP  = eprs_pkg::TIMER_WRAP_DEF,
    parameter int PERIOD_BITS = eprs_pkg::PERIOD_BITS_DEF,
    localparam int M_TDATA_W  =
        ((PERIOD_BITS + 4 * eprs_pkg::DUTY_W + 2 * eprs_pkg::PULSE_W + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [eprs_pkg::S_TDATA_W-1:0]     s_tdata,   // capture_value, high_speed
    input  logic [eprs_pkg::S_TUSER_W-1:0]     s_tuser,   // op
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // measured_period, duty_right, duty_left, compare_right, compare_left,
    // pulses_right, pulses_left
    output logic [M_TDATA_W-1:0]               m_tdata,
    output logic [eprs_pkg::M_TUSER_W-1:0]     m_tuser,   // adjusted
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [eprs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [eprs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import eprs_pkg::*;

    localparam int C_W = $clog2(TIMER_WRAP);

    // Configuration registers
    logic [TGT_CFG_W-1:0] tgt_r_reg, tgt_l_reg;
    logic [DUTY_W-1:0]    pwm_reg;
    logic                 cfg_acc, duty_load;

    // Input stage
    logic                 v1_reg;
    eprs_op_t             op1_reg;
    logic [C_W-1:0]       c1_reg;
    logic                 hs1_reg;
    logic [C_W-1:0]       cap_ticks;
    logic                 s_acc, adv;

    // Wheel events and results
    eprs_ev_t             ev_r, ev_l;
    logic [PERIOD_BITS-1:0] per_r, per_l, per_sel;
    logic                 adj_r, adj_l;
    logic [DUTY_W-1:0]    duty_r_next, duty_l_next;
    logic [PULSE_W-1:0]   pulses_r_next, pulses_l_next;

    // Result register
    logic                   out_valid_reg;
    logic [PERIOD_BITS-1:0] per_reg;
    logic [DUTY_W-1:0]      duty_r_reg, duty_l_reg, cmp_r_reg, cmp_l_reg;
    logic [PULSE_W-1:0]     pulses_r_reg, pulses_l_reg;
    logic                   adj_reg;

    // Configuration write decode
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign duty_load = cfg_acc && (cfg_index == REG_INITIAL_DUTY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_r_reg     <= TARGET_RIGHT_RST;
            tgt_l_reg     <= TARGET_LEFT_RST;
            pwm_reg       <= PWM_PERIOD_RST;
        end else if (cfg_acc) begin
            unique case (cfg_index)
                REG_TARGET_RIGHT: tgt_r_reg     <= cfg_data;
                REG_TARGET_LEFT:  tgt_l_reg     <= cfg_data;
                REG_INITIAL_DUTY: ;   // loaded straight into both wheel duties
                REG_PWM_PERIOD:   pwm_reg       <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: stage moves on when the result register is free or draining
    assign adv      = v1_reg && (!out_valid_reg || m_tready);
    assign s_tready = !v1_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    // Capture reduced modulo the timer wrap ahead of the input register
    eprs_wrap #(
        .TIMER_WRAP (TIMER_WRAP)
    ) u_wrap (
        .cap_raw   (s_tdata[CAP_W-1:0]),
        .cap_ticks (cap_ticks)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_acc) begin
            v1_reg <= 1'b1;
        end else if (adv) begin
            v1_reg <= 1'b0;
        end
        if (s_acc) begin
            op1_reg <= eprs_op_t'(s_tuser);
            c1_reg  <= cap_ticks;
            hs1_reg <= s_tdata[CAP_W];
        end
    end

    // Event strobes per wheel
    always_comb begin
        ev_r = '0;
        ev_l = '0;
        ev_r.hs = hs1_reg;
        ev_l.hs = hs1_reg;
        if (adv) begin
            unique case (op1_reg)
                OP_OVERFLOW: begin
                    ev_r.ovf = 1'b1;
                    ev_l.ovf = 1'b1;
                end
                OP_CAP_RIGHT: ev_r.cap = 1'b1;
                OP_CAP_LEFT:  ev_l.cap = 1'b1;
                OP_RESTART: begin
                    ev_r.restart = 1'b1;
                    ev_l.restart = 1'b1;
                end
                default: ;
            endcase
        end
    end

    eprs_wheel #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .TIMER_WRAP  (TIMER_WRAP),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_wheel_right (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ev          (ev_r),
        .cap_ticks   (c1_reg),
        .target      (tgt_r_reg),
        .pwm_period  (pwm_reg),
        .duty_load   (duty_load),
        .duty_init   (cfg_data[DUTY_W-1:0]),
        .period      (per_r),
        .adjusted    (adj_r),
        .duty_next   (duty_r_next),
        .pulses_next (pulses_r_next)
    );

    eprs_wheel #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .TIMER_WRAP  (TIMER_WRAP),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_wheel_left (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ev          (ev_l),
        .cap_ticks   (c1_reg),
        .target      (tgt_l_reg),
        .pwm_period  (pwm_reg),
        .duty_load   (duty_load),
        .duty_init   (cfg_data[DUTY_W-1:0]),
        .period      (per_l),
        .adjusted    (adj_l),
        .duty_next   (duty_l_next),
        .pulses_next (pulses_l_next)
    );

    // Measured period only for captures
    always_comb begin
        unique case (op1_reg)
            OP_CAP_RIGHT: per_sel = per_r;
            OP_CAP_LEFT:  per_sel = per_l;
            default:      per_sel = '0;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (adv) begin
            per_reg      <= per_sel;
            duty_r_reg   <= duty_r_next;
            duty_l_reg   <= duty_l_next;
            cmp_r_reg    <= hs1_reg ? (duty_r_next >> 1) : duty_r_next;
            cmp_l_reg    <= hs1_reg ? (duty_l_next >> 1) : duty_l_next;
            pulses_r_reg <= pulses_r_next;
            pulses_l_reg <= pulses_l_next;
            adj_reg      <= adj_r || adj_l;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({pulses_l_reg, pulses_r_reg, cmp_l_reg, cmp_r_reg,
                                  duty_l_reg, duty_r_reg, per_reg});
    assign m_tuser  = adj_reg;

    // Both stages are empty the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !v1_reg))
        else $error("pipeline not empty after reset");

    // A held input word is not dropped while the result side stalls
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !adv) |=> (v1_reg && $stable(op1_reg) && $stable(c1_reg)))
        else $error("input stage word lost under stall");

    // Compare values are the duties, or the duties halved
    a_compare: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((cmp_r_reg == duty_r_reg || cmp_r_reg == (duty_r_reg >> 1)) &&
                           (cmp_l_reg == duty_l_reg || cmp_l_reg == (duty_l_reg >> 1))))
        else $error("compare value inconsistent with duty");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the two-wheel encoder period speed regulator core.
module tb;
    import eprs_pkg::*;

    localparam int  M_W        = ((PERIOD_BITS_DEF + 4 * DUTY_W + 2 * PULSE_W + 7) / 8) * 8;
    localparam longint PER_TOP = (longint'(1) << PERIOD_BITS_DEF) - 1;
    localparam longint PULSE_TOP = (longint'(1) << PULSE_W) - 1;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  BLOCK_WORDS = 130;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(4);

    // One result word, split into its fields
    typedef struct packed {
        logic [PERIOD_BITS_DEF-1:0] period;
        logic [DUTY_W-1:0]          duty_r;
        logic [DUTY_W-1:0]          duty_l;
        logic [DUTY_W-1:0]          cmp_r;
        logic [DUTY_W-1:0]          cmp_l;
        logic [PULSE_W-1:0]         pulses_r;
        logic [PULSE_W-1:0]         pulses_l;
        logic                       adjusted;
    } speed_word_t;

    // Directed row: event, capture, speed mode, and a literal result where chk is set
    typedef struct packed {
        eprs_op_t          op;
        logic [CAP_W-1:0]  cap;
        logic              hs;
        logic              chk;
        speed_word_t       want;
    } event_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata = '0;
    logic [S_TUSER_W-1:0]    s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_W-1:0]          m_tdata;
    logic [M_TUSER_W-1:0]    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // Shadow of the regulator: registers and per-wheel state (0 right, 1 left)
    logic [TGT_CFG_W-1:0]    tgt_ticks [2];
    logic [DUTY_W-1:0]       init_duty_q;
    logic [DUTY_W-1:0]       pwm_top;
    longint                  wheel_ofs [2];
    longint                  wheel_sum [2];
    int                      wheel_cnt [2];
    logic [DUTY_W-1:0]       wheel_duty [2];
    longint                  wheel_pulses [2];

    speed_word_t             speed_q [$];
    int                      n_err = 0;
    int                      n_sent = 0;
    int                      src_idle = 0;
    int                      snk_idle = 0;
    int                      cycles = 0;
    logic                    mode_hs = 1'b0;

    // Directed events under the reset settings
    event_row_t dir_rows [22] = '{
        '{OP_OVERFLOW,  16'h0000, 1'b0, 1'b1,
          '{24'd0, 10'd240, 10'd240, 10'd240, 10'd240, 24'd0, 24'd0, 1'b0}},
        '{OP_CAP_RIGHT, 16'h0000, 1'b0, 1'b1,
          '{24'd65536, 10'd240, 10'd240, 10'd240, 10'd240, 24'd1, 24'd0, 1'b0}},
        '{OP_CAP_RIGHT, 16'hFFFF, 1'b0, 1'b0, '0},
        // capture below the previous one with no wrap: period reads zero
        '{OP_CAP_RIGHT, 16'h0000, 1'b0, 1'b1,
          '{24'd0, 10'd240, 10'd240, 10'd240, 10'd240, 24'd3, 24'd0, 1'b0}},
        // restart in high speed: counts cleared, compares halved
        '{OP_RESTART,   16'h0000, 1'b1, 1'b1,
          '{24'd0, 10'd240, 10'd240, 10'd120, 10'd120, 24'd0, 24'd0, 1'b0}},
        // right wheel too fast: six periods of 10000 ticks, duty steps down
        '{OP_CAP_RIGHT, 16'd10000, 1'b0, 1'b0, '0},
        '{OP_CAP_RIGHT, 16'd20000, 1'b0, 1'b0, '0},
        '{OP_CAP_RIGHT, 16'd30000, 1'b0, 1'b0, '0},
        '{OP_CAP_RIGHT, 16'd40000, 1'b0, 1'b0, '0},
        '{OP_CAP_RIGHT, 16'd50000, 1'b0, 1'b0, '0},
        '{OP_CAP_RIGHT, 16'd60000, 1'b0, 1'b1,
          '{24'd10000, 10'd239, 10'd240, 10'd239, 10'd240, 24'd6, 24'd0, 1'b1}},
        // left wheel: one wrap per pulse, last sample in high speed (doubled step)
        '{OP_CAP_LEFT,  16'h0000, 1'b0, 1'b0, '0},
        '{OP_OVERFLOW,  16'hA5A5, 1'b0, 1'b0, '0},
        '{OP_CAP_LEFT,  16'h0000, 1'b0, 1'b0, '0},
        '{OP_OVERFLOW,  16'h5A5A, 1'b1, 1'b0, '0},
        '{OP_CAP_LEFT,  16'h0000, 1'b0, 1'b0, '0},
        '{OP_OVERFLOW,  16'hFFFF, 1'b0, 1'b0, '0},
        '{OP_CAP_LEFT,  16'h0000, 1'b0, 1'b0, '0},
        '{OP_OVERFLOW,  16'h0000, 1'b0, 1'b0, '0},
        '{OP_CAP_LEFT,  16'h0000, 1'b0, 1'b0, '0},
        '{OP_OVERFLOW,  16'h0000, 1'b0, 1'b0, '0},
        '{OP_CAP_LEFT,  16'h0000, 1'b1, 1'b1,
          '{24'd65536, 10'd239, 10'd238, 10'd119, 10'd119, 24'd6, 24'd6, 1'b1}}
    };

    encoder_period_speed_regulator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Run guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic log_mismatch(input string what, input longint got, input longint want);
        if (n_err < 50)
            $display("ERROR @%0t %s: got %0d, expected %0d", $time, what, got, want);
        n_err++;
    endtask

    // Duty moves one step toward the target, clamped to the PWM period
    function automatic logic [DUTY_W-1:0] step_duty(input logic [DUTY_W-1:0] d,
            input longint avg, input longint tg, input int stp);
        int v;
        v = d;
        if (avg > tg) begin
            v = d + stp;
            if (v > pwm_top) v = pwm_top;
        end else if (avg < tg) begin
            v = (d >= stp) ? d - stp : 0;
            if (v > pwm_top) v = pwm_top;
        end
        return v[DUTY_W-1:0];
    endfunction

    // Advance the shadow state by one event and build the word it should produce
    function automatic speed_word_t regulate(input eprs_op_t op, input logic [CAP_W-1:0] cap,
            input logic hs);
        speed_word_t r;
        longint per;
        longint c;
        longint tg;
        int w;
        int i;
        r = '0;
        per = 0;
        case (op)
            OP_OVERFLOW: begin
                for (i = 0; i < 2; i++) begin
                    wheel_ofs[i] = wheel_ofs[i] + TIMER_WRAP_DEF;
                    if (wheel_ofs[i] > PER_TOP) wheel_ofs[i] = PER_TOP;
                end
            end
            OP_CAP_RIGHT, OP_CAP_LEFT: begin
                w = (op == OP_CAP_RIGHT) ? 0 : 1;
                c = longint'(cap) % TIMER_WRAP_DEF;
                per = wheel_ofs[w] + c;
                if (per < 0) per = 0;
                if (per > PER_TOP) per = PER_TOP;
                wheel_ofs[w] = -c;
                if (wheel_pulses[w] < PULSE_TOP) wheel_pulses[w]++;
                wheel_cnt[w]++;
                wheel_sum[w] += per;
                if (wheel_cnt[w] >= AVG_SAMPLES_DEF) begin
                    tg = longint'(tgt_ticks[w]) << hs;
                    wheel_duty[w] = step_duty(wheel_duty[w], wheel_sum[w] / AVG_SAMPLES_DEF,
                                              tg, 1 << hs);
                    wheel_cnt[w] = 0;
                    wheel_sum[w] = 0;
                    r.adjusted = 1'b1;
                end
            end
            default: begin
                for (i = 0; i < 2; i++) begin
                    wheel_cnt[i] = 0;
                    wheel_sum[i] = 0;
                    wheel_pulses[i] = 0;
                end
            end
        endcase
        r.period   = per[PERIOD_BITS_DEF-1:0];
        r.duty_r   = wheel_duty[0];
        r.duty_l   = wheel_duty[1];
        r.cmp_r    = wheel_duty[0] >> hs;
        r.cmp_l    = wheel_duty[1] >> hs;
        r.pulses_r = wheel_pulses[0][PULSE_W-1:0];
        r.pulses_l = wheel_pulses[1][PULSE_W-1:0];
        return r;
    endfunction

    // Send one event word; the literal result replaces the predicted one where chk is set
    task automatic push_word(input eprs_op_t op, input logic [CAP_W-1:0] cap, input logic hs,
            input logic chk, input speed_word_t want);
        speed_word_t pred;
        if ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({hs, cap});
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pred = regulate(op, cap, hs);
        speed_q.push_back(chk ? want : pred);
        n_sent++;
    endtask

    // Produce a given period on one wheel: wraps as needed, then the capture
    task automatic drive_period(input int w, input longint per, input logic hs);
        longint d;
        longint k;
        d = per - wheel_ofs[w];
        if (d < 0) d = 0;
        k = d / TIMER_WRAP_DEF;
        if (k > 300) k = 300;
        repeat (k) push_word(OP_OVERFLOW, CAP_W'($urandom), hs, 1'b0, '0);
        push_word(w == 0 ? OP_CAP_RIGHT : OP_CAP_LEFT, CAP_W'(d % TIMER_WRAP_DEF), hs,
                  1'b0, '0);
    endtask

    // Mostly regular pulse trains near the target, some restarts and stray events
    task automatic run_traffic(input int words);
        int goal;
        int r;
        int sel;
        int w;
        longint tg;
        longint per;
        goal = n_sent + words;
        while (n_sent < goal) begin
            r = $urandom_range(99);
            if ($urandom_range(19) == 0) mode_hs = ~mode_hs;
            if (r < 2) begin
                push_word(OP_RESTART, CAP_W'($urandom), 1'($urandom), 1'b0, '0);
            end else if (r < 8) begin
                push_word(eprs_op_t'($urandom_range(3)), CAP_W'($urandom), 1'($urandom),
                          1'b0, '0);
            end else begin
                w   = $urandom_range(1);
                tg  = longint'(tgt_ticks[w]) << mode_hs;
                sel = $urandom_range(199);
                if (sel == 0)
                    per = PER_TOP + $urandom_range(70000);
                else if (sel < 120 && tg <= 300000)
                    per = tg + $urandom_range(4) - 2;
                else if (sel < 170)
                    per = $urandom_range(150000);
                else
                    per = $urandom_range(3000);
                if (per < 0) per = 0;
                drive_period(w, per, mode_hs);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TARGET_RIGHT: tgt_ticks[0] = val;
            REG_TARGET_LEFT:  tgt_ticks[1] = val;
            REG_INITIAL_DUTY: begin
                init_duty_q   = val[DUTY_W-1:0];
                wheel_duty[0] = init_duty_q;
                wheel_duty[1] = init_duty_q;
            end
            REG_PWM_PERIOD:   pwm_top = val[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // Wait for the pipeline to drain before touching the registers
    task automatic drain;
        do @(posedge aclk); while (speed_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Duty registers get random upper bits, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] duty_word(input int v);
        return {(CFG_DATA_W - DUTY_W)'($urandom), DUTY_W'(v)};
    endfunction

    task automatic load_setting(input longint tr, input longint tl, input int init,
            input int pwm);
        drain();
        write_reg(REG_TARGET_RIGHT, CFG_DATA_W'(tr));
        write_reg(REG_TARGET_LEFT, CFG_DATA_W'(tl));
        write_reg(REG_INITIAL_DUTY, duty_word(init));
        write_reg(REG_PWM_PERIOD, duty_word(pwm));
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure and the field-by-field check
    always @(posedge aclk) begin
        speed_word_t got;
        speed_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle);
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[23:0], m_tdata[33:24], m_tdata[43:34], m_tdata[53:44],
                        m_tdata[63:54], m_tdata[87:64], m_tdata[111:88], m_tuser[0]};
                if (speed_q.size() == 0) begin
                    log_mismatch("unexpected word, period", got.period, 0);
                end else begin
                    want = speed_q.pop_front();
                    if (got.period !== want.period)
                        log_mismatch("measured_period", got.period, want.period);
                    if (got.duty_r !== want.duty_r)
                        log_mismatch("duty_right", got.duty_r, want.duty_r);
                    if (got.duty_l !== want.duty_l)
                        log_mismatch("duty_left", got.duty_l, want.duty_l);
                    if (got.cmp_r !== want.cmp_r)
                        log_mismatch("compare_right", got.cmp_r, want.cmp_r);
                    if (got.cmp_l !== want.cmp_l)
                        log_mismatch("compare_left", got.cmp_l, want.cmp_l);
                    if (got.pulses_r !== want.pulses_r)
                        log_mismatch("pulses_right", got.pulses_r, want.pulses_r);
                    if (got.pulses_l !== want.pulses_l)
                        log_mismatch("pulses_left", got.pulses_l, want.pulses_l);
                    if (got.adjusted !== want.adjusted)
                        log_mismatch("adjusted", got.adjusted, want.adjusted);
                end
            end
        end
    end

    // Main sequence
    initial begin
        int i;
        tgt_ticks[0] = TARGET_RIGHT_RST;
        tgt_ticks[1] = TARGET_LEFT_RST;
        init_duty_q  = INITIAL_DUTY_RST;
        pwm_top      = PWM_PERIOD_RST;
        for (i = 0; i < 2; i++) begin
            wheel_ofs[i]    = 0;
            wheel_sum[i]    = 0;
            wheel_cnt[i]    = 0;
            wheel_duty[i]   = INITIAL_DUTY_RST;
            wheel_pulses[i] = 0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // sender gaps light, receiver stalls heavy
        src_idle = 27;
        snk_idle = 61;
        for (i = 0; i < 22; i++)
            push_word(dir_rows[i].op, dir_rows[i].cap, dir_rows[i].hs, dir_rows[i].chk,
                      dir_rows[i].want);
        run_traffic(BLOCK_WORDS);
        load_setting(1, 8388607, 1023, 1023);
        run_traffic(BLOCK_WORDS);

        // sender gaps heavy, receiver stalls light
        src_idle = 61;
        snk_idle = 27;
        load_setting($urandom_range(140000, 1000), $urandom_range(140000, 1000),
                     $urandom_range(1023), $urandom_range(1023, 1));
        run_traffic(BLOCK_WORDS);
        load_setting(8388607, 1, 0, 1);
        @(posedge aclk);
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        run_traffic(BLOCK_WORDS);

        // full rate both ways
        src_idle = 0;
        snk_idle = 0;
        load_setting($urandom_range(70000, 60000), $urandom_range(70000, 60000),
                     $urandom_range(1023), $urandom_range(1023, 1));
        run_traffic(BLOCK_WORDS);
        load_setting($urandom_range(5000, 1), $urandom_range(5000, 1), 1023, 512);
        run_traffic(BLOCK_WORDS);

        while (speed_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
